FILE: hdl/arq_sender_window_timers_assert.svh
// Assertion macros used by the sender window datapath.
`ifndef ARQ_SENDER_WINDOW_TIMERS_ASSERT_SVH
`define ARQ_SENDER_WINDOW_TIMERS_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define ARQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The antecedent in one cycle implies the consequent in the next.
`define ARQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/arq_pkg.sv
`default_nettype none
package arq_pkg;

    localparam logic [1:0] REQ_SEND    = 2'd0;
    localparam logic [1:0] REQ_ACK     = 2'd1;
    localparam logic [1:0] REQ_RESCHED = 2'd2;
    localparam logic [1:0] REQ_EXPIRE  = 2'd3;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;
    localparam int BUF_IW      = 4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SLIDE,
        S_XSTART,
        S_XSCAN,
        S_XPICK,
        S_ESTART,
        S_ESCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic slide;
        logic scan_start;
        logic scan_run;
        logic scan_expire;
        logic pick;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic is_expire;
        logic ack_ok;
        logic slide_more;
        logic scan_done;
        logic found;
        logic cnt_last;
        logic emit_last;
    } t_stat;

endpackage
`default_nettype wire

FILE: hdl/arq_ram.sv
`default_nettype none
module arq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/arq_ctrl.sv
`default_nettype none
module arq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    input  wire arq_pkg::t_stat i_stat,
    output arq_pkg::t_cmd       o_cmd
);

    arq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            arq_pkg::S_IDLE: begin
                // Nothing is taken while reset is held.
                o_stall = !i_rst_n;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = arq_pkg::S_EXEC;
                end
            end
            arq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                priority if (i_stat.is_expire) begin
                    n_state = arq_pkg::S_XSTART;
                end else if (i_stat.ack_ok) begin
                    n_state = arq_pkg::S_SLIDE;
                end else begin
                    n_state = arq_pkg::S_ESTART;
                end
            end
            arq_pkg::S_SLIDE: begin
                o_cmd.slide = 1'b1;
                if (!i_stat.slide_more) begin
                    n_state = arq_pkg::S_ESTART;
                end
            end
            arq_pkg::S_XSTART: begin
                o_cmd.scan_start = 1'b1;
                n_state          = arq_pkg::S_XSCAN;
            end
            arq_pkg::S_XSCAN: begin
                o_cmd.scan_run    = 1'b1;
                o_cmd.scan_expire = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = arq_pkg::S_XPICK;
                end
            end
            arq_pkg::S_XPICK: begin
                o_cmd.pick = 1'b1;
                if (!i_stat.found || i_stat.cnt_last) begin
                    n_state = arq_pkg::S_ESTART;
                end else begin
                    n_state = arq_pkg::S_XSTART;
                end
            end
            arq_pkg::S_ESTART: begin
                o_cmd.scan_start = 1'b1;
                n_state          = arq_pkg::S_ESCAN;
            end
            arq_pkg::S_ESCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = arq_pkg::S_EMIT;
                end
            end
            arq_pkg::S_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = arq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = arq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/arq_datapath.sv
`default_nettype none
module arq_datapath #(
    parameter int WINDOW = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire arq_pkg::t_cmd  i_cmd,
    output arq_pkg::t_stat      o_stat,
    input  wire logic [1:0]     i_req_type,
    input  wire logic [31:0]    i_seq_in,
    input  wire logic [47:0]    i_time_value,
    output logic                o_status,
    output logic      [31:0]    o_seq_out,
    output logic                o_seq_valid,
    output logic                o_last,
    output logic      [31:0]    o_window_base,
    output logic      [31:0]    o_next_seq,
    output logic                o_earliest_valid,
    output logic      [47:0]    o_earliest_time
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int PW = $clog2(WINDOW + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);

    logic [1:0]  r_req;
    logic [31:0] r_seq;
    logic [47:0] r_tv;

    logic [WINDOW-1:0] r_out, r_armed;
    logic [31:0]       r_base, r_next;
    logic [SW-1:0]     r_base_slot, r_next_slot;

    // Scan pointer, issue stage and best candidate.
    logic [PW-1:0] r_ptr;
    logic [SW-1:0] r_pslot;
    logic          r_p_v, r_p_ok;
    logic [31:0]   r_p_seq;
    logic [SW-1:0] r_p_slot;
    logic          r_found;
    logic [47:0]   r_bt;
    logic [31:0]   r_bseq;
    logic [SW-1:0] r_bslot;

    logic [31:0]              r_buf [arq_pkg::MAX_RESULTS];
    logic [arq_pkg::CNT_W-1:0] r_cnt;
    logic [arq_pkg::BUF_IW-1:0] r_eptr;
    logic                     r_res_status, r_res_sv;
    logic [31:0]              r_res_seq;

    logic [31:0]   occ, seq_off;
    logic          in_win, full, acc_ok, scanning, take;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] slot_a;
    logic          ram_we;
    logic [SW-1:0] ram_waddr;
    logic [47:0]   rdata;

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] s);
        wrap_inc = (s == LAST_SLOT) ? '0 : s + SW'(1);
    endfunction

    assign occ      = r_next - r_base;
    assign seq_off  = r_seq - r_base;
    assign in_win   = seq_off < occ;
    assign full     = occ >= 32'(WINDOW);
    assign slot_sum = {1'b0, r_base_slot} + seq_off[SW:0];
    assign slot_a   = (slot_sum >= (SW+1)'(WINDOW)) ? SW'(slot_sum - (SW+1)'(WINDOW))
                                                    : slot_sum[SW-1:0];
    assign acc_ok   = in_win && r_out[slot_a];
    assign scanning = i_cmd.scan_run && (r_ptr < PW'(WINDOW));
    assign take     = r_p_v && r_p_ok && (!i_cmd.scan_expire || rdata <= r_tv) &&
                      (!r_found || rdata < r_bt);

    assign ram_we    = i_cmd.exec && ((r_req == arq_pkg::REQ_SEND && !full) ||
                       (r_req == arq_pkg::REQ_RESCHED && acc_ok));
    assign ram_waddr = (r_req == arq_pkg::REQ_SEND) ? r_next_slot : slot_a;

    arq_ram #(
        .WIDTH (48),
        .DEPTH (WINDOW)
    ) u_deadline (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_tv),
        .i_raddr (r_pslot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_seq <= i_seq_in;
            r_tv  <= i_time_value;
        end
        if (i_cmd.exec) begin
            r_res_status <= 1'b1;
            r_res_sv     <= 1'b0;
            r_res_seq    <= '0;
            if (r_req == arq_pkg::REQ_SEND && !full) begin
                r_res_status <= 1'b0;
                r_res_sv     <= 1'b1;
                r_res_seq    <= r_next;
            end else if (r_req != arq_pkg::REQ_SEND && acc_ok) begin
                r_res_status <= 1'b0;
            end
        end
        if (scanning) begin
            r_p_seq  <= r_base + 32'(r_ptr);
            r_p_slot <= r_pslot;
            r_p_ok   <= r_armed[r_pslot];
        end
        if (take) begin
            r_bt    <= rdata;
            r_bseq  <= r_p_seq;
            r_bslot <= r_p_slot;
        end
        if (i_cmd.pick && r_found) begin
            r_buf[r_cnt[arq_pkg::BUF_IW-1:0]] <= r_bseq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out       <= '0;
            r_armed     <= '0;
            r_base      <= '0;
            r_next      <= '0;
            r_base_slot <= '0;
            r_next_slot <= '0;
            r_ptr       <= '0;
            r_pslot     <= '0;
            r_p_v       <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_eptr      <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_cnt  <= '0;
                r_eptr <= '0;
                unique case (r_req)
                    arq_pkg::REQ_SEND: begin
                        if (!full) begin
                            r_out[r_next_slot]   <= 1'b1;
                            r_armed[r_next_slot] <= 1'b1;
                            r_next               <= r_next + 32'd1;
                            r_next_slot          <= wrap_inc(r_next_slot);
                        end
                    end
                    arq_pkg::REQ_ACK: begin
                        if (acc_ok) begin
                            r_out[slot_a]   <= 1'b0;
                            r_armed[slot_a] <= 1'b0;
                        end
                    end
                    arq_pkg::REQ_RESCHED: begin
                        if (acc_ok) begin
                            r_armed[slot_a] <= 1'b1;
                        end
                    end
                    arq_pkg::REQ_EXPIRE: begin
                    end
                endcase
            end
            if (i_cmd.slide && o_stat.slide_more) begin
                r_base      <= r_base + 32'd1;
                r_base_slot <= wrap_inc(r_base_slot);
            end
            if (i_cmd.scan_start) begin
                r_ptr   <= '0;
                r_pslot <= r_base_slot;
                r_p_v   <= 1'b0;
                r_found <= 1'b0;
            end else begin
                r_p_v <= scanning;
                if (scanning) begin
                    r_ptr   <= r_ptr + PW'(1);
                    r_pslot <= wrap_inc(r_pslot);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.pick && r_found) begin
                r_armed[r_bslot] <= 1'b0;
                r_cnt            <= r_cnt + arq_pkg::CNT_W'(1);
            end
            if (i_cmd.emit_next) begin
                r_eptr <= r_eptr + arq_pkg::BUF_IW'(1);
            end
        end
    end

    always_comb begin
        o_stat.is_expire  = (r_req == arq_pkg::REQ_EXPIRE);
        o_stat.ack_ok     = (r_req == arq_pkg::REQ_ACK) && acc_ok;
        o_stat.slide_more = (r_base != r_next) && !r_out[r_base_slot];
        o_stat.scan_done  = (r_ptr == PW'(WINDOW)) && !r_p_v;
        o_stat.found      = r_found;
        o_stat.cnt_last   = (r_cnt == arq_pkg::CNT_W'(arq_pkg::MAX_RESULTS - 1));
        o_stat.emit_last  = !o_stat.is_expire || (r_cnt == '0) ||
                            ({1'b0, r_eptr} == r_cnt - arq_pkg::CNT_W'(1));
    end

    always_comb begin
        if (o_stat.is_expire) begin
            o_status    = 1'b0;
            o_seq_valid = (r_cnt != '0);
            o_seq_out   = (r_cnt != '0) ? r_buf[r_eptr] : '0;
        end else begin
            o_status    = r_res_status;
            o_seq_valid = r_res_sv;
            o_seq_out   = r_res_seq;
        end
    end

    assign o_last           = o_stat.emit_last;
    assign o_window_base    = r_base;
    assign o_next_seq       = r_next;
    assign o_earliest_valid = r_found;
    assign o_earliest_time  = r_found ? r_bt : '0;

`include "arq_sender_window_timers_assert.svh"

    `ARQ_ASSERT_ALWAYS(a_armed_outstanding, (r_armed & ~r_out) == '0, "armed slot not outstanding")
    `ARQ_ASSERT_ALWAYS(a_occupancy, (r_next - r_base) <= 32'(WINDOW), "window overfilled")
    `ARQ_ASSERT_ALWAYS(a_count, r_cnt <= arq_pkg::CNT_W'(arq_pkg::MAX_RESULTS), "too many expired")
    `ARQ_ASSERT_NEXT(a_pick_disarms, i_cmd.pick && r_found, !r_armed[$past(r_bslot)], "expired slot still armed")

endmodule
`default_nettype wire

FILE: hdl/arq_sender_window_timers.sv
// Each request runs an execute step and then a final scan for the earliest timer before its
// result is shown; an accepted ack slides the base once per freed slot before that scan.
// An expire with k due packets first runs min(k+1,16) deadline scans, then shows one result
// per cycle while i_stall is low. Only one transaction is handled at a time, bounded by the
// slot scans through the single read port of the deadline memory. Synchronous active-low
// reset empties the window and disarms all timers at once; deadlines are not cleared.
`default_nettype none
module arq_sender_window_timers #(
    parameter int WINDOW = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_seq_in,
    input  wire logic [47:0] i_time_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic      [31:0] o_seq_out,
    output logic             o_seq_valid,
    output logic             o_last,
    output logic      [31:0] o_window_base,
    output logic      [31:0] o_next_seq,
    output logic             o_earliest_valid,
    output logic      [47:0] o_earliest_time
);

    // The controller sequences each request: an execute step, then a base slide for an accepted
    // ack, repeated deadline scans for an expire, and a final scan for the earliest timer.
    // Results are held in the datapath and shown one transaction at a time afterwards,
    // so every result reports the window and timer state after the whole request.
    arq_pkg::t_cmd  cmd;
    arq_pkg::t_stat stat;

    arq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath owns the slot bits, the deadline memory and the result buffer.
    arq_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req_type),
        .i_seq_in         (i_seq_in),
        .i_time_value     (i_time_value),
        .o_status         (o_status),
        .o_seq_out        (o_seq_out),
        .o_seq_valid      (o_seq_valid),
        .o_last           (o_last),
        .o_window_base    (o_window_base),
        .o_next_seq       (o_next_seq),
        .o_earliest_valid (o_earliest_valid),
        .o_earliest_time  (o_earliest_time)
    );

endmodule
`default_nettype wire
